FILE: sv/bbe_pkg.sv
package bbe_pkg;

    // Default sizing
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_RADIUS = 7;

    // Register reset values
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int RST_KERNEL_SIZE  = 3;

    // Configuration port
    localparam int CFG_DATA_W = 13;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2
    } cfg_index_t;

    // Input op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic [7:0]  blurred_value;
        logic [10:0] out_col;
        logic [11:0] out_row;
        logic        frame_last;
    } res_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

endpackage

FILE: sv/box_blur_edge_normalized_core.sv
// Channel  | Direction | Handshake             | Beat
// ---------+-----------+-----------------------+--------------------------------
// pix      | in        | pix_valid / pix_stall | pix_item_t: op, pixel_value
// res      | out       | res_valid / res_stall | res_item_t: value, col, row, last
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A beat that releases no result leaves the input free for the next beat. A beat
// that releases a result holds pix_stall until its result is registered: N window
// pixels read one per cycle from the line store's read port, then a one-bit-per-cycle
// divider over the SUMW-bit window sum.
// Reset clears counters and control; the line store needs no clearing.
// A stalled result holds in the output register; the next beat is accepted
// meanwhile, and its result waits until the register is free.
module box_blur_edge_normalized_core #(
    parameter int MAX_WIDTH  = bbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbe_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = bbe_pkg::DEF_MAX_RADIUS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  bbe_pkg::pix_item_t              pix_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output bbe_pkg::res_item_t              res_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bbe_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int RGW   = $clog2(RING);
    localparam int AW    = RGW + XW;
    localparam int DEPTH = RING << XW;
    localparam int KMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SUMW  = $clog2(KMAX * 255 + 1);
    localparam int CNTW  = $clog2(KMAX + 1);
    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

    // Configuration and frame position
    logic [WW-1:0]  width_reg;
    logic [HW-1:0]  height_reg;
    logic [3:0]     ksize_reg;
    logic [XW-1:0]  in_col_reg, in_col_next;
    logic [YW-1:0]  in_row_reg, in_row_next;
    logic [RGW-1:0] in_ring_reg, in_ring_next;
    logic           fdone_reg, fdone_next;
    logic [XW-1:0]  res_col_reg, res_col_next;
    logic [YW-1:0]  res_row_reg, res_row_next;
    logic [RGW-1:0] res_ring_reg, res_ring_next;

    // Window scan
    state_t         state_reg, state_next;
    logic [YW-1:0]  r1_reg, y_reg;
    logic [XW-1:0]  c0_reg, c1_reg, x_reg;
    logic [RGW-1:0] y_ring_reg;
    logic [SUMW-1:0] sum_reg;
    logic [CNTW-1:0] cnt_reg;
    logic           rd_vld_reg;
    logic [10:0]    o_col_reg;
    logic [11:0]    o_row_reg;
    logic           o_last_reg;
    res_item_t      res_reg;
    logic           res_valid_reg;

    // Combinational helpers
    logic           pix_acc, cfg_acc, cfg_ok, wr_en, due, last, res_acc;
    logic [RW-1:0]  rad;
    logic [2:0]     half_k;
    logic [XW:0]    col_p1, res_col_p1, ncol_sum, w_m1;
    logic [YW:0]    row_p1, res_row_p1, nrow_sum, h_m1;
    logic [XW-1:0]  ncol, c0;
    logic [YW-1:0]  nrow, r0;
    logic [RW-1:0]  back;
    logic [RGW:0]   ring0;
    logic           scan_end, scan_enter;
    logic [7:0]     rd_data;
    logic [SUMW-1:0] quot;
    logic           div_done;
    logic [RGW-1:0] y_ring_inc;

    assign pix_acc  = pix_valid && !pix_stall;
    assign cfg_ready = 1'b1;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign res_acc  = res_valid_reg && !res_stall;

    // Radius, clamped to the store depth
    assign half_k = ksize_reg[3:1];
    assign rad    = (32'(half_k) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(half_k);

    // Config value check: zero, or an unused index, is rejected
    always_comb
    begin
        unique case (cfg_index)
            CFG_IMAGE_WIDTH:  cfg_ok = cfg_data[11:0] != '0;
            CFG_IMAGE_HEIGHT: cfg_ok = cfg_data[12:0] != '0;
            CFG_KERNEL_SIZE:  cfg_ok = cfg_data[3:0] != '0;
            default:          cfg_ok = 1'b0;
        endcase
    end

    // Input position after this beat
    assign wr_en  = pix_acc && (pix_data.op == OP_PIXEL) && !fdone_reg;
    assign col_p1 = {1'b0, in_col_reg} + (XW+1)'(1);
    assign row_p1 = {1'b0, in_row_reg} + (YW+1)'(1);
    assign w_m1   = (XW+1)'(width_reg) - (XW+1)'(1);
    assign h_m1   = (YW+1)'(height_reg) - (YW+1)'(1);

    // Result release test and window bounds
    assign ncol_sum   = {1'b0, res_col_reg} + (XW+1)'(rad);
    assign nrow_sum   = {1'b0, res_row_reg} + (YW+1)'(rad);
    assign ncol       = (ncol_sum > w_m1) ? w_m1[XW-1:0] : ncol_sum[XW-1:0];
    assign nrow       = (nrow_sum > h_m1) ? h_m1[YW-1:0] : nrow_sum[YW-1:0];
    assign c0         = (res_col_reg >= XW'(rad)) ? res_col_reg - XW'(rad) : '0;
    assign r0         = (res_row_reg >= YW'(rad)) ? res_row_reg - YW'(rad) : '0;
    assign back       = RW'(res_row_reg - r0);
    assign ring0      = ({1'b0, res_ring_reg} >= (RGW+1)'(back))
                      ? {1'b0, res_ring_reg} - (RGW+1)'(back)
                      : {1'b0, res_ring_reg} + (RGW+1)'(RING) - (RGW+1)'(back);
    assign res_col_p1 = {1'b0, res_col_reg} + (XW+1)'(1);
    assign res_row_p1 = {1'b0, res_row_reg} + (YW+1)'(1);
    assign last       = (res_row_p1 >= (YW+1)'(height_reg))
                     && (res_col_p1 >= (XW+1)'(width_reg));

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_ring_next  = in_ring_reg;
        fdone_next    = fdone_reg;
        res_col_next  = res_col_reg;
        res_row_next  = res_row_reg;
        res_ring_next = res_ring_reg;
        due           = 1'b0;
        if (wr_en)
        begin
            if (col_p1 >= (XW+1)'(width_reg))
            begin
                in_col_next = '0;
                if (row_p1 >= (YW+1)'(height_reg))
                begin
                    fdone_next = 1'b1;
                end
                else
                begin
                    in_row_next  = row_p1[YW-1:0];
                    in_ring_next = (in_ring_reg == RGW'(RING - 1)) ? '0
                                 : in_ring_reg + RGW'(1);
                end
            end
            else
            begin
                in_col_next = col_p1[XW-1:0];
            end
        end
        // Release when the input has passed the window's last pixel
        due = pix_acc && (fdone_next || (in_row_next > nrow)
              || ((in_row_next == nrow) && (in_col_next > ncol)));
        if (due)
        begin
            if (last)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_ring_next  = '0;
                fdone_next    = 1'b0;
                res_col_next  = '0;
                res_row_next  = '0;
                res_ring_next = '0;
            end
            else if (res_col_p1 >= (XW+1)'(width_reg))
            begin
                res_col_next  = '0;
                res_row_next  = res_row_p1[YW-1:0];
                res_ring_next = (res_ring_reg == RGW'(RING - 1)) ? '0
                              : res_ring_reg + RGW'(1);
            end
            else
            begin
                res_col_next = res_col_p1[XW-1:0];
            end
        end
    end

    // Registers and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WW'(RST_W);
            height_reg   <= HW'(RST_H);
            ksize_reg    <= 4'(RST_KERNEL_SIZE);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            fdone_reg    <= 1'b0;
            res_col_reg  <= '0;
            res_row_reg  <= '0;
            res_ring_reg <= '0;
        end
        else if (cfg_acc && cfg_ok)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_reg <= (32'(cfg_data[11:0]) > MAX_WIDTH) ? WW'(MAX_WIDTH)
                               : WW'(cfg_data[11:0]);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= (32'(cfg_data[12:0]) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                : HW'(cfg_data[12:0]);
                end
                CFG_KERNEL_SIZE:
                begin
                    ksize_reg <= cfg_data[3:0];
                end
                default:
                begin
                    ksize_reg <= ksize_reg;
                end
            endcase
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            fdone_reg    <= 1'b0;
            res_col_reg  <= '0;
            res_row_reg  <= '0;
            res_ring_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_ring_reg  <= in_ring_next;
            fdone_reg    <= fdone_next;
            res_col_reg  <= res_col_next;
            res_row_reg  <= res_row_next;
            res_ring_reg <= res_ring_next;
        end
    end

    // Window scan bookkeeping
    assign scan_enter = (state_reg == S_IDLE) && due;
    assign scan_end   = (x_reg == c1_reg) && (y_reg == r1_reg);
    assign y_ring_inc = (y_ring_reg == RGW'(RING - 1)) ? '0 : y_ring_reg + RGW'(1);

    always_ff @(posedge clk)
    begin
        if (scan_enter)
        begin
            r1_reg     <= nrow;
            c0_reg     <= c0;
            c1_reg     <= ncol;
            x_reg      <= c0;
            y_reg      <= r0;
            y_ring_reg <= ring0[RGW-1:0];
            sum_reg    <= '0;
            cnt_reg    <= '0;
            o_col_reg  <= 11'(res_col_reg);
            o_row_reg  <= 12'(res_row_reg);
            o_last_reg <= last;
        end
        else
        begin
            if (state_reg == S_SCAN)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (x_reg == c1_reg)
                begin
                    x_reg      <= c0_reg;
                    y_reg      <= y_reg + YW'(1);
                    y_ring_reg <= y_ring_inc;
                end
                else
                begin
                    x_reg <= x_reg + XW'(1);
                end
            end
            if (rd_vld_reg)
            begin
                sum_reg <= sum_reg + SUMW'(rd_data);
            end
        end
    end

    // Control: read-valid pipe, state, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == S_SCAN);
            state_reg  <= state_next;
            if ((state_reg == S_OUT) && (!res_valid_reg || !res_stall))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_acc)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!res_valid_reg || !res_stall))
        begin
            res_reg.blurred_value <= quot[7:0];
            res_reg.out_col       <= o_col_reg;
            res_reg.out_row       <= o_row_reg;
            res_reg.frame_last    <= o_last_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (due) state_next = S_SCAN;
            S_SCAN:  if (scan_end) state_next = S_DRAIN;
            S_DRAIN: state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_OUT;
            S_OUT:   if (!res_valid_reg || !res_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign pix_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    bbe_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({in_ring_reg, in_col_reg}),
        .wr_data (pix_data.pixel_value),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr ({y_ring_reg, x_reg}),
        .rd_data (rd_data)
    );

    bbe_divider #(
        .NUMW (SUMW),
        .DENW (CNTW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_START),
        .num   (sum_reg),
        .den   (cnt_reg),
        .done  (div_done),
        .quot  (quot)
    );

`ifndef SYNTHESIS
    a_div_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> (cnt_reg != '0))
        else $error("divider started with empty window");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide phase");
    a_in_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (YW+1)'(in_row_reg) < (YW+1)'(height_reg))
        else $error("input row past frame");
    a_res_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        (!fdone_reg && (state_reg == S_IDLE)) |-> (res_row_reg <= in_row_reg))
        else $error("result row ahead of input row");
`endif

endmodule

FILE: sv/bbe_line_store.sv
module bbe_line_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/bbe_divider.sv
module bbe_divider #(
    parameter int NUMW = 16,
    parameter int DENW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [NUMW-1:0] quot
);

    localparam int SW = (NUMW > 1) ? $clog2(NUMW) : 1;

    logic            busy_reg;
    logic            done_reg;
    logic [SW-1:0]   step_reg;
    logic [NUMW-1:0] quo_reg;
    logic [DENW-1:0] rem_reg;
    logic [DENW:0]   rem_sh;
    logic            ge;
    logic [DENW:0]   rem_sub;

    // One restoring step per cycle
    assign rem_sh  = {rem_reg, quo_reg[NUMW-1]};
    assign ge      = rem_sh >= {1'b0, den};
    assign rem_sub = ge ? (rem_sh - {1'b0, den}) : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(NUMW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUMW-2:0], ge};
            rem_reg <= rem_sub[DENW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
